// ===== rtl/core/dbca_pkg.sv =====
`default_nettype none

package dbca_pkg;

  localparam int DIGITS       = 6;
  localparam int NUM_W        = 20;
  localparam int BCD_W        = 4 * DIGITS;
  localparam int PTR_W        = $clog2(DIGITS);
  localparam int TICKS_PER_MS = 1000;
  localparam int PRE_W        = $clog2(TICKS_PER_MS);
  localparam int DAB_STEPS    = 5;
  localparam int DAB_STAGES   = NUM_W / DAB_STEPS;

  localparam logic [NUM_W-1:0] NUM_MAX = NUM_W'(999999);

  localparam int THP_W = 10;
  localparam int CNT_W = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TONE_HALF_PERIOD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_BEEP_TOGGLES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_BEEP_TOGGLES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BEEP_GAP_MS        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_GAP_MS       = 3'd4;

  localparam logic [THP_W-1:0] RST_TONE_HALF_PERIOD   = 10'd122;
  localparam logic [CNT_W-1:0] RST_LONG_BEEP_TOGGLES  = 16'd1000;
  localparam logic [CNT_W-1:0] RST_SHORT_BEEP_TOGGLES = 16'd400;
  localparam logic [CNT_W-1:0] RST_BEEP_GAP_MS        = 16'd500;
  localparam logic [CNT_W-1:0] RST_DIGIT_GAP_MS       = 16'd1000;

  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic [NUM_W-1:0] bin;
  } dab_t;

  // DAB_STEPS double-dabble steps: add 3 to any digit of 5 or more, then shift in a bit
  function automatic dab_t dabble(input dab_t din);
    dab_t d;
    d = din;
    for (int s = 0; s < DAB_STEPS; s++) begin
      for (int k = 0; k < DIGITS; k++) begin
        if (d.bcd[4*k +: 4] >= 4'd5) begin
          d.bcd[4*k +: 4] = d.bcd[4*k +: 4] + 4'd3;
        end
      end
      d.bcd = {d.bcd[BCD_W-2:0], d.bin[NUM_W-1]};
      d.bin = {d.bin[NUM_W-2:0], 1'b0};
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/decimal_beep_code_annunciator_top.sv =====
// Beeps a decimal number (0 to 999999, larger values clamped) on a buzzer,
// most significant digit first without leading zeros; zero is one long beep,
// a digit d is d short beeps each followed by a beep gap, and digits are
// separated by a digit gap. Each input beat is either a start (action 1) or
// one microsecond tick (action 0); a start while busy is ignored and is not
// a tick. One result beat follows every input beat, in order. An input beat
// can be taken every clock while the result side does not stall; a result
// passes the four-stage binary-to-decimal pipeline ahead of the sequencer.
// Configuration must be written only while idle; the block does not check.
`default_nettype none

module decimal_beep_code_annunciator_top
  import dbca_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire                  action,
  input  wire  [NUM_W-1:0]     number,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic                 buzzer_out,
  output logic                 led_out,
  output logic                 busy_res,
  input  wire                  wr_en,
  input  wire  [CFG_IDX_W-1:0] wr_index,
  input  wire  [CNT_W-1:0]     wr_data
);

  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_BEEP      = 2'd1;
  localparam logic [1:0] PH_BEEP_GAP  = 2'd2;
  localparam logic [1:0] PH_DIGIT_GAP = 2'd3;

  // configuration
  logic [THP_W-1:0] tone_half_period;
  logic [CNT_W-1:0] long_beep_toggles;
  logic [CNT_W-1:0] short_beep_toggles;
  logic [CNT_W-1:0] beep_gap_ms;
  logic [CNT_W-1:0] digit_gap_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_half_period   <= RST_TONE_HALF_PERIOD;
      long_beep_toggles  <= RST_LONG_BEEP_TOGGLES;
      short_beep_toggles <= RST_SHORT_BEEP_TOGGLES;
      beep_gap_ms        <= RST_BEEP_GAP_MS;
      digit_gap_ms       <= RST_DIGIT_GAP_MS;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TONE_HALF_PERIOD:   tone_half_period   <= wr_data[THP_W-1:0];
        REG_LONG_BEEP_TOGGLES:  long_beep_toggles  <= wr_data;
        REG_SHORT_BEEP_TOGGLES: short_beep_toggles <= wr_data;
        REG_BEEP_GAP_MS:        beep_gap_ms        <= wr_data;
        REG_DIGIT_GAP_MS:       digit_gap_ms       <= wr_data;
        default: ;
      endcase
    end
  end

  // decimal conversion pipeline
  logic vld [DAB_STAGES+1];
  logic act [DAB_STAGES+1];
  dab_t dab [DAB_STAGES+1];
  logic move [DAB_STAGES+1];
  logic free [DAB_STAGES+2];
  logic out_ready;
  logic in_accept;

  assign out_ready = !out_valid || !out_stall;

  always_comb begin
    free[DAB_STAGES+1] = out_ready;
    for (int i = DAB_STAGES; i >= 0; i--) begin
      move[i] = vld[i] && free[i+1];
      free[i] = !vld[i] || move[i];
    end
  end

  assign in_stall  = !free[0];
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= DAB_STAGES; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      if (in_accept) begin
        vld[0] <= 1'b1;
      end else if (move[0]) begin
        vld[0] <= 1'b0;
      end
      for (int i = 1; i <= DAB_STAGES; i++) begin
        if (move[i-1]) begin
          vld[i] <= 1'b1;
        end else if (move[i]) begin
          vld[i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      act[0]     <= action;
      dab[0].bcd <= '0;
      dab[0].bin <= (number > NUM_MAX) ? NUM_MAX : number;
    end
    for (int i = 1; i <= DAB_STAGES; i++) begin
      if (move[i-1]) begin
        act[i] <= act[i-1];
        dab[i] <= dabble(dab[i-1]);
      end
    end
  end

  // sequencer
  logic             fire;
  logic [3:0]       digit_store [DIGITS];
  logic [PTR_W-1:0] digit_pointer;
  logic [3:0]       beeps_left;
  logic [CNT_W-1:0] toggles_left;
  logic [THP_W-1:0] tone_counter;
  logic [PRE_W-1:0] ms_prescaler;
  logic [CNT_W-1:0] gap_ms_left;
  logic [1:0]       phase;
  logic             buzzer_level;
  logic             led_level;

  logic [3:0]       digit_store_next [DIGITS];
  logic [PTR_W-1:0] digit_pointer_next;
  logic [3:0]       beeps_left_next;
  logic [CNT_W-1:0] toggles_left_next;
  logic [THP_W-1:0] tone_counter_next;
  logic [PRE_W-1:0] ms_prescaler_next;
  logic [CNT_W-1:0] gap_ms_left_next;
  logic [1:0]       phase_next;
  logic             buzzer_level_next;
  logic             led_level_next;

  logic [PTR_W-1:0] new_ptr;
  logic [3:0]       new_digit;
  logic [3:0]       cur_digit;
  logic [THP_W-1:0] tc_dec;
  logic [THP_W-1:0] thp_eff;
  logic             gap_open;
  logic [PRE_W-1:0] pre_step;
  logic [CNT_W-1:0] gap_step;

  assign fire = move[DAB_STAGES];

  always_comb begin
    new_ptr = '0;
    for (int k = 0; k < DIGITS; k++) begin
      if (dab[DAB_STAGES].bcd[4*k +: 4] != 4'd0) begin
        new_ptr = PTR_W'(k);
      end
    end
  end

  assign new_digit = dab[DAB_STAGES].bcd[4*new_ptr +: 4];
  assign cur_digit = digit_store[digit_pointer];
  assign tc_dec    = (tone_counter != '0) ? tone_counter - 1'b1 : '0;
  assign thp_eff   = (tone_half_period == '0) ? THP_W'(1) : tone_half_period;
  assign gap_open  = (gap_ms_left != '0);

  always_comb begin
    if (ms_prescaler == PRE_W'(TICKS_PER_MS - 1)) begin
      pre_step = '0;
      gap_step = gap_ms_left - 1'b1;
    end else begin
      pre_step = ms_prescaler + 1'b1;
      gap_step = gap_ms_left;
    end
  end

  always_comb begin
    digit_store_next   = digit_store;
    digit_pointer_next = digit_pointer;
    beeps_left_next    = beeps_left;
    toggles_left_next  = toggles_left;
    tone_counter_next  = tone_counter;
    ms_prescaler_next  = ms_prescaler;
    gap_ms_left_next   = gap_ms_left;
    phase_next         = phase;
    buzzer_level_next  = buzzer_level;
    led_level_next     = led_level;

    if (act[DAB_STAGES]) begin
      if (phase == PH_IDLE) begin
        for (int k = 0; k < DIGITS; k++) begin
          digit_store_next[k] = dab[DAB_STAGES].bcd[4*k +: 4];
        end
        digit_pointer_next = new_ptr;
        beeps_left_next    = new_digit;
        toggles_left_next  = (new_digit == 4'd0) ? long_beep_toggles : short_beep_toggles;
        tone_counter_next  = '0;
        buzzer_level_next  = 1'b0;
        led_level_next     = 1'b1;
        phase_next         = PH_BEEP;
      end
    end else begin
      unique case (phase)
        PH_BEEP: begin
          if (tc_dec == '0) begin
            if (toggles_left != '0) begin
              buzzer_level_next = !buzzer_level;
              toggles_left_next = toggles_left - 1'b1;
              tone_counter_next = thp_eff;
            end else begin
              tone_counter_next = '0;
              buzzer_level_next = 1'b0;
              led_level_next    = 1'b0;
              if (cur_digit == 4'd0) begin
                if (digit_pointer == '0) begin
                  phase_next = PH_IDLE;
                end else begin
                  digit_pointer_next = digit_pointer - 1'b1;
                  gap_ms_left_next   = digit_gap_ms;
                  ms_prescaler_next  = '0;
                  phase_next         = PH_DIGIT_GAP;
                end
              end else begin
                if (beeps_left != 4'd0) begin
                  beeps_left_next = beeps_left - 1'b1;
                end
                gap_ms_left_next  = beep_gap_ms;
                ms_prescaler_next = '0;
                phase_next        = PH_BEEP_GAP;
              end
            end
          end else begin
            tone_counter_next = tc_dec;
          end
        end
        PH_BEEP_GAP: begin
          if (gap_open) begin
            ms_prescaler_next = pre_step;
            gap_ms_left_next  = gap_step;
          end else if (beeps_left != 4'd0) begin
            toggles_left_next = short_beep_toggles;
            tone_counter_next = '0;
            buzzer_level_next = 1'b0;
            led_level_next    = 1'b1;
            phase_next        = PH_BEEP;
          end else if (digit_pointer == '0) begin
            phase_next = PH_IDLE;
          end else begin
            digit_pointer_next = digit_pointer - 1'b1;
            gap_ms_left_next   = digit_gap_ms;
            ms_prescaler_next  = '0;
            phase_next         = PH_DIGIT_GAP;
          end
        end
        PH_DIGIT_GAP: begin
          if (gap_open) begin
            ms_prescaler_next = pre_step;
            gap_ms_left_next  = gap_step;
          end else begin
            beeps_left_next   = cur_digit;
            toggles_left_next = (cur_digit == 4'd0) ? long_beep_toggles : short_beep_toggles;
            tone_counter_next = '0;
            buzzer_level_next = 1'b0;
            led_level_next    = 1'b1;
            phase_next        = PH_BEEP;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIGITS; k++) begin
        digit_store[k] <= 4'd0;
      end
      digit_pointer <= '0;
      beeps_left    <= '0;
      toggles_left  <= '0;
      tone_counter  <= '0;
      ms_prescaler  <= '0;
      gap_ms_left   <= '0;
      phase         <= PH_IDLE;
      buzzer_level  <= 1'b0;
      led_level     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (fire) begin
        digit_store   <= digit_store_next;
        digit_pointer <= digit_pointer_next;
        beeps_left    <= beeps_left_next;
        toggles_left  <= toggles_left_next;
        tone_counter  <= tone_counter_next;
        ms_prescaler  <= ms_prescaler_next;
        gap_ms_left   <= gap_ms_left_next;
        phase         <= phase_next;
        buzzer_level  <= buzzer_level_next;
        led_level     <= led_level_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign buzzer_out = buzzer_level;
  assign led_out    = led_level;
  assign busy_res   = (phase != PH_IDLE);

  a_led_tracks_beep: assert property (@(posedge clk) disable iff (rst)
    led_level == (phase == PH_BEEP))
    else $error("led level out of step with beep phase");

  a_quiet_when_idle: assert property (@(posedge clk) disable iff (rst)
    !busy_res |-> !buzzer_out && !led_out)
    else $error("buzzer or led active while idle");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(phase) && $stable(digit_pointer) && $stable(toggles_left))
    else $error("sequencer moved while result beat stalled");

  a_pointer_range: assert property (@(posedge clk) disable iff (rst)
    digit_pointer < PTR_W'(DIGITS))
    else $error("digit pointer beyond digit store");

  a_accept_when_empty: assert property (@(posedge clk) disable iff (rst)
    !vld[0] |-> !in_stall)
    else $error("input stalled with empty front stage");

endmodule

`default_nettype wire

// ===== test/decimal_beep_code_annunciator_top_test.sv =====
`default_nettype none

module decimal_beep_code_annunciator_top_test;
  import dbca_pkg::*;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_START = 1'b1;
  localparam int LIMIT_CYCLES = 100_000;
  localparam int RANDOM_PHASES = 4;
  localparam int BEATS_PER_PHASE = 40;

  typedef enum logic [1:0] {SILENT, BEEPING, BEEP_PAUSE, DIGIT_PAUSE} stage_t;

  typedef struct packed {
    logic buzzer;
    logic led;
    logic busy;
  } levels_t;

  class beep_sequence_checker;
    logic [THP_W-1:0] half_period;
    logic [CNT_W-1:0] long_toggles;
    logic [CNT_W-1:0] short_toggles;
    logic [CNT_W-1:0] pause_ms;
    logic [CNT_W-1:0] digit_pause_ms;

    logic [3:0]       digits [DIGITS];
    int unsigned      ptr;
    logic [3:0]       beeps_to_go;
    logic [CNT_W-1:0] toggles_to_go;
    logic [THP_W-1:0] tone_cnt;
    int unsigned      ms_sub;
    logic [CNT_W-1:0] ms_to_go;
    stage_t           stage;
    logic             buzz;
    logic             lamp;

    levels_t levels_due[$];
    int errors;

    function new();
      half_period    = RST_TONE_HALF_PERIOD;
      long_toggles   = RST_LONG_BEEP_TOGGLES;
      short_toggles  = RST_SHORT_BEEP_TOGGLES;
      pause_ms       = RST_BEEP_GAP_MS;
      digit_pause_ms = RST_DIGIT_GAP_MS;
      foreach (digits[i]) digits[i] = '0;
      ptr           = 0;
      beeps_to_go   = '0;
      toggles_to_go = '0;
      tone_cnt      = '0;
      ms_sub        = 0;
      ms_to_go      = '0;
      stage         = SILENT;
      buzz          = 1'b0;
      lamp          = 1'b0;
      errors        = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
      case (idx)
        REG_TONE_HALF_PERIOD:   half_period    = data[THP_W-1:0];
        REG_LONG_BEEP_TOGGLES:  long_toggles   = data;
        REG_SHORT_BEEP_TOGGLES: short_toggles  = data;
        REG_BEEP_GAP_MS:        pause_ms       = data;
        REG_DIGIT_GAP_MS:       digit_pause_ms = data;
        default: ;
      endcase
    endfunction

    function logic [3:0] current_digit();
      return (ptr < DIGITS) ? digits[ptr] : 4'd0;
    endfunction

    function void open_beep(logic [CNT_W-1:0] toggles);
      toggles_to_go = toggles;
      tone_cnt      = '0;
      buzz          = 1'b0;
      lamp          = 1'b1;
      stage         = BEEPING;
    endfunction

    function void open_digit();
      logic [3:0] d;
      d = current_digit();
      beeps_to_go = d;
      open_beep((d == 4'd0) ? long_toggles : short_toggles);
    endfunction

    function void open_pause(logic [CNT_W-1:0] ms, stage_t st);
      ms_to_go = ms;
      ms_sub   = 0;
      stage    = st;
    endfunction

    function void digit_finished();
      if (ptr == 0) begin
        stage = SILENT;
      end else begin
        ptr--;
        open_pause(digit_pause_ms, DIGIT_PAUSE);
      end
    endfunction

    // true once the pause has fully run out
    function bit pause_over();
      if (ms_to_go != '0) begin
        ms_sub++;
        if (ms_sub >= TICKS_PER_MS) begin
          ms_sub = 0;
          ms_to_go--;
        end
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void tick();
      case (stage)
        BEEPING: begin
          if (tone_cnt != '0) tone_cnt--;
          if (tone_cnt == '0) begin
            if (toggles_to_go != '0) begin
              buzz = ~buzz;
              toggles_to_go--;
              tone_cnt = (half_period != '0) ? half_period : THP_W'(1);
            end else begin
              buzz = 1'b0;
              lamp = 1'b0;
              if (current_digit() == 4'd0) begin
                digit_finished();
              end else begin
                if (beeps_to_go != '0) beeps_to_go--;
                open_pause(pause_ms, BEEP_PAUSE);
              end
            end
          end
        end
        BEEP_PAUSE: begin
          if (pause_over()) begin
            if (beeps_to_go != '0) open_beep(short_toggles);
            else digit_finished();
          end
        end
        DIGIT_PAUSE: begin
          if (pause_over()) open_digit();
        end
        default: stage = SILENT;
      endcase
    endfunction

    function void load(logic [NUM_W-1:0] num);
      int unsigned n;
      n = 32'((num > NUM_MAX) ? NUM_MAX : num);
      ptr = 0;
      for (int i = 0; i < DIGITS; i++) begin
        digits[i] = 4'(n % 10);
        if (digits[i] != 4'd0) ptr = i;
        n = n / 10;
      end
      open_digit();
    endfunction

    function void note_beat(logic act, logic [NUM_W-1:0] num);
      if (act == ACT_START) begin
        if (stage == SILENT) load(num);
      end else begin
        tick();
      end
      levels_due.push_back('{buzzer: buzz, led: lamp, busy: (stage != SILENT)});
    endfunction

    function void check_beat(levels_t got);
      levels_t want;
      if (levels_due.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      want = levels_due.pop_front();
      if (got.buzzer !== want.buzzer) begin
        $error("buzzer_out: expected %0d, got %0d", want.buzzer, got.buzzer);
        errors++;
      end
      if (got.led !== want.led) begin
        $error("led_out: expected %0d, got %0d", want.led, got.led);
        errors++;
      end
      if (got.busy !== want.busy) begin
        $error("busy_res: expected %0d, got %0d", want.busy, got.busy);
        errors++;
      end
    endfunction

    function int pending();
      return levels_due.size();
    endfunction

    function bit busy();
      return stage != SILENT;
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic                 action;
  logic [NUM_W-1:0]     number;
  logic                 out_valid;
  logic                 out_stall;
  logic                 buzzer_out;
  logic                 led_out;
  logic                 busy_res;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [CNT_W-1:0]     wr_data;

  bit idle_en;
  int stall_left;
  beep_sequence_checker chk = new();

  decimal_beep_code_annunciator_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .number     (number),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .buzzer_out (buzzer_out),
    .led_out    (led_out),
    .busy_res   (busy_res),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver side stall bursts
  initial begin
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (rst || !idle_en) begin
        out_stall  = 1'b0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        out_stall  = 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      chk.check_beat('{buzzer: buzzer_out, led: led_out, busy: busy_res});
    end
  end

  function automatic logic [NUM_W-1:0] rand_number();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return NUM_MAX;
      2, 3:    return NUM_W'($urandom_range(0, (1 << NUM_W) - 1));
      4, 5, 6: return NUM_W'($urandom_range(0, 99));
      7, 8:    return NUM_W'($urandom_range(0, 9999));
      default: return NUM_W'($urandom_range(0, 999999));
    endcase
  endfunction

  task automatic send_beat(input logic act, input logic [NUM_W-1:0] num);
    int gap;
    gap = (idle_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
    @(negedge clk);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    action   = act;
    number   = num;
    do @(posedge clk); while (in_stall);
    chk.note_beat(act, num);
  endtask

  task automatic run_to_idle();
    while (chk.busy()) begin
      if ($urandom_range(0, 31) == 0) send_beat(ACT_START, rand_number());
      else send_beat(ACT_TICK, NUM_W'($urandom));
    end
  endtask

  task automatic announce(input logic [NUM_W-1:0] num);
    send_beat(ACT_START, num);
    run_to_idle();
  endtask

  task automatic random_beat();
    if (chk.busy()) begin
      if ($urandom_range(0, 19) == 0) send_beat(ACT_START, rand_number());
      else send_beat(ACT_TICK, NUM_W'($urandom));
    end else begin
      if ($urandom_range(0, 4) == 0) send_beat(ACT_TICK, NUM_W'($urandom));
      else send_beat(ACT_START, rand_number());
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = val;
    @(posedge clk);
    chk.set_reg(idx, val);
  endtask

  task automatic apply_config(input int thp, input int lng, input int sht,
                              input int bgap, input int dgap);
    wait_drained();
    write_reg(REG_TONE_HALF_PERIOD, CNT_W'(thp));
    write_reg(REG_LONG_BEEP_TOGGLES, CNT_W'(lng));
    write_reg(REG_SHORT_BEEP_TOGGLES, CNT_W'(sht));
    write_reg(REG_BEEP_GAP_MS, CNT_W'(bgap));
    write_reg(REG_DIGIT_GAP_MS, CNT_W'(dgap));
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    action   = ACT_TICK;
    number   = '0;
    wr_en    = 1'b0;
    wr_index = '0;
    wr_data  = '0;
    idle_en  = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst     = 1'b0;
    idle_en = 1'b1;

    // shortest beeps, no pauses
    apply_config(1, 1, 1, 0, 0);
    send_beat(ACT_TICK, '0);
    send_beat(ACT_START, '0);
    send_beat(ACT_START, NUM_W'(5));
    run_to_idle();
    announce(NUM_W'(100000));
    announce(NUM_W'(10));
    announce(NUM_W'(7));

    // longer half period
    apply_config(100, 1, 1, 0, 0);
    announce(NUM_W'(1));

    // wide counts; zero never reaches either pause
    apply_config(1, 257, 65535, 65535, 65535);
    announce('0);

    // zero half period and zero toggle counts, clamped number
    apply_config(0, 0, 0, 0, 0);
    announce('0);
    announce(NUM_W'(305));
    announce(NUM_W'((1 << NUM_W) - 1));

    // one millisecond between digits, digit zero last
    apply_config(2, 2, 1, 0, 1);
    announce(NUM_W'(10));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_config($urandom_range(0, 3), $urandom_range(0, 6), $urandom_range(0, 3), 0, 0);
      idle_en = (p < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      repeat (BEATS_PER_PHASE) random_beat();
      run_to_idle();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/dbca_pkg.sv
rtl/core/decimal_beep_code_annunciator_top.sv
test/decimal_beep_code_annunciator_top_test.sv
